>>> hdl/dett_pkg.sv
// shared types, codes and widths for the deferred event timer table
package dett_pkg;

   localparam int SOUND_W = 16;
   localparam int TIME_W = 24;
   localparam int CMD_W = 2;
   localparam int SLOT_W = 4;
   localparam int SLOT_COUNT_DEFAULT = 16;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [SOUND_W-1:0] sound_id;
      logic [TIME_W-1:0] delay_time;
      logic [TIME_W-1:0] time_step;
   } req_word_type;

   typedef struct packed {
      logic [SOUND_W-1:0] fired_id;
      logic [SLOT_W-1:0] fired_slot;
      logic last;
   } rsp_word_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic op_insert;
      logic op_cancel;
      logic op_tick;
      logic pop;
      logic [SOUND_W-1:0] sound_id;
      logic [TIME_W-1:0] delay_time;
      logic [TIME_W-1:0] time_step;
   } cell_ctrl_type;

   // rippled from cell to cell, low index first
   typedef struct packed {
      logic taken;
      logic found;
      logic more;
      logic [SOUND_W-1:0] fired_id;
      logic [SLOT_W-1:0] fired_slot;
   } chain_link_type;

endpackage

>>> hdl/deferred_event_timer_table_top.sv
// top level of the deferred event timer table: cell row and drain control
//
// usage
// - req channel: one word per command (insert, tick, cancel); accepted when
//   req_valid is high and req_stall is low
// - rsp channel: one word per expired event, lowest slot first, last set on
//   the final word of a tick; taken when rsp_valid is high and rsp_stall low
// - insert and cancel finish at the accepting edge; the next word can be
//   taken in the following cycle, so they run at one word per cycle
// - a tick updates every slot at the accepting edge, then drains the
//   expired slots one per cycle, while the output register is free,
//   serially through the single rsp output register
// - req_stall is high while a tick drains; a held rsp_stall holds the
//   output word and pauses the drain without losing anything
// - synchronous reset empties the table at once and drops any word in
//   the output register
// - the lowest expired slot is picked in the cycle after the tick is
//   accepted and loaded once the output register is free, raising rsp_valid
module deferred_event_timer_table_top
   import dett_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_word_type req_word,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_word_type rsp_word
);

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic req_accept;
   logic rsp_free;
   logic rsp_load;
   cell_ctrl_type ctrl;
   chain_link_type link [SLOT_COUNT+1];

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   // output register can take a word if empty or emptied this cycle
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   // drain the lowest expired slot whenever the output register is free
   assign rsp_load = (state_ff == ST_DRAIN) && link[SLOT_COUNT].found && rsp_free;

   always_comb begin
      ctrl.op_insert = req_accept && (req_word.cmd == CMD_INSERT);
      ctrl.op_cancel = req_accept && (req_word.cmd == CMD_CANCEL);
      ctrl.op_tick = req_accept && (req_word.cmd == CMD_TICK);
      ctrl.pop = rsp_load;
      ctrl.sound_id = req_word.sound_id;
      ctrl.delay_time = req_word.delay_time;
      ctrl.time_step = req_word.time_step;
   end

   // head of the chain: nothing taken or found above slot 0
   assign link[0] = '0;

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      dett_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .ctrl(ctrl),
         .link_in(link[i]),
         .link_out(link[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in = rsp_word_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.op_tick) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!link[SLOT_COUNT].found) begin
               state_in = ST_IDLE;
            end else if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_word_in.fired_id = link[SLOT_COUNT].fired_id;
               rsp_word_in.fired_slot = link[SLOT_COUNT].fired_slot;
               rsp_word_in.last = !link[SLOT_COUNT].more;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   // no expired slot may wait while new commands are taken
   a_idle_no_expired: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !link[SLOT_COUNT].found)
      else $error("expired slot pending while idle");

   // the word marked last leaves no expired slot behind
   a_last_drains_all: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !link[SLOT_COUNT].more) |=> !link[SLOT_COUNT].found)
      else $error("expired slot left after last word");

   // drain only ever starts from an accepted tick
   a_drain_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_DRAIN) |-> $past(ctrl.op_tick))
      else $error("drain entered without a tick");

   // a word marked not last is followed by another expired slot
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && link[SLOT_COUNT].more) |=> link[SLOT_COUNT].found)
      else $error("word not marked last but nothing follows");

endmodule

>>> hdl/dett_cell.sv
// one slot of the timer table with its link to the next slot
module dett_cell
   import dett_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input logic clock,
   input logic reset,
   input cell_ctrl_type ctrl,
   input chain_link_type link_in,
   output chain_link_type link_out
);

   localparam logic [SLOT_W-1:0] CELL_SLOT = SLOT_W'(CELL_INDEX);

   logic valid_ff, valid_in;
   logic expired_ff, expired_in;
   logic [SOUND_W-1:0] sound_ff, sound_in;
   logic [TIME_W-1:0] remaining_ff, remaining_in;
   logic take;
   logic hit;
   logic timeout;

   always_comb begin
      take = ctrl.op_insert && !valid_ff && !link_in.taken;
      hit = valid_ff && (sound_ff == ctrl.sound_id);
      timeout = remaining_ff <= ctrl.time_step;

      valid_in = valid_ff;
      expired_in = expired_ff;
      sound_in = sound_ff;
      remaining_in = remaining_ff;

      if (take) begin
         valid_in = 1'b1;
         sound_in = ctrl.sound_id;
         remaining_in = ctrl.delay_time;
      end
      if (ctrl.op_cancel && hit) begin
         valid_in = 1'b0;
      end
      if (ctrl.op_tick && valid_ff) begin
         // saturating subtract, a slot at zero leaves the table
         remaining_in = timeout ? '0 : remaining_ff - ctrl.time_step;
         if (timeout) begin
            valid_in = 1'b0;
            expired_in = 1'b1;
         end
      end
      if (ctrl.pop && expired_ff && !link_in.found) begin
         expired_in = 1'b0;
      end
   end

   always_comb begin
      link_out.taken = link_in.taken || !valid_ff;
      link_out.found = link_in.found || expired_ff;
      link_out.more = link_in.more || (link_in.found && expired_ff);
      if (link_in.found) begin
         link_out.fired_id = link_in.fired_id;
         link_out.fired_slot = link_in.fired_slot;
      end else if (expired_ff) begin
         link_out.fired_id = sound_ff;
         link_out.fired_slot = CELL_SLOT;
      end else begin
         link_out.fired_id = '0;
         link_out.fired_slot = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         expired_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         expired_ff <= expired_in;
      end
      sound_ff <= sound_in;
      remaining_ff <= remaining_in;
   end

endmodule
